// ===== hw/rtl/sip_pkg.sv =====
package sip_pkg;

  localparam int MAX_STRING_DEF = 1024;
  localparam int MAX_NAME_DEF   = 255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 3;
  localparam int LEN_W      = 11;

  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_OK     = 3'd1;
  localparam logic [2:0] ST_SYNTAX = 3'd2;
  localparam logic [2:0] ST_ESC    = 3'd3;
  localparam logic [2:0] ST_EARLY  = 3'd4;
  localparam logic [2:0] ST_LONG   = 3'd5;

  localparam logic [2:0] K_NONE     = 3'd0;
  localparam logic [2:0] K_NAME     = 3'd1;
  localparam logic [2:0] K_STR      = 3'd2;
  localparam logic [2:0] K_NAME_END = 3'd3;
  localparam logic [2:0] K_STR_END  = 3'd4;
  localparam logic [2:0] K_NUM_END  = 3'd5;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
    logic       letter;
    logic       digit;
    logic       name_char;
    logic       hex_ok;
    logic [3:0] hex_val;
  } class_t;

endpackage

// ===== hw/rtl/sip_front.sv =====
module sip_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sip_pkg::IN_DATA_W-1:0] s_tdata,   // text_byte[7:0]
  input  logic                         s_tlast,
  input  logic                         q_full,
  output logic                         push,
  output sip_pkg::class_t              entry
);

  logic [7:0] low;
  logic       is_letter;
  logic       is_digit;
  logic       is_hexlet;

  assign low       = s_tdata | 8'h20;
  assign is_letter = (low >= 8'h61) && (low <= 8'h7A);
  assign is_digit  = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
  assign is_hexlet = (low >= 8'h61) && (low <= 8'h66);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    entry           = '0;
    entry.text      = s_tdata;
    entry.fin       = s_tlast;
    entry.letter    = is_letter;
    entry.digit     = is_digit;
    entry.name_char = is_letter || is_digit || (s_tdata == sip_pkg::CH_DOLLAR)
                      || (s_tdata == sip_pkg::CH_UNDER);
    entry.hex_ok    = is_digit || is_hexlet;
    if (is_digit) begin
      entry.hex_val = s_tdata[3:0];
    end else begin
      entry.hex_val = low[3:0] + 4'd9;
    end
  end

endmodule

// ===== hw/rtl/sip_queue.sv =====
module sip_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sip_pkg::class_t wr_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sip_pkg::class_t rd_entry
);

  sip_pkg::class_t              mem [sip_pkg::QUEUE_DEPTH];
  logic [sip_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sip_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sip_pkg::QPTR_W:0]     count;
  logic                         do_pop;

  assign full      = (count == (sip_pkg::QPTR_W+1)'(sip_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign rd_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/sip_back.sv =====
module sip_back #(
  parameter int MAX_STRING = sip_pkg::MAX_STRING_DEF,
  parameter int MAX_NAME   = sip_pkg::MAX_NAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sip_pkg::class_t               e,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sip_pkg::OUT_DATA_W-1:0] m_tdata,  // status[2:0], out_byte[10:3],
                                                   // value_length[21:11],
                                                   // number_value[85:22], zero[87:86]
  output logic [sip_pkg::OUT_USER_W-1:0] m_tuser   // out_kind[2:0]
);

  localparam int MAXLEN = (MAX_STRING > MAX_NAME) ? MAX_STRING : MAX_NAME;
  localparam int CW     = $clog2(MAXLEN + 1);

  localparam logic [2:0] PH_OPEN       = 3'd0;
  localparam logic [2:0] PH_ELEM       = 3'd1;
  localparam logic [2:0] PH_NAME_FIRST = 3'd2;
  localparam logic [2:0] PH_NAME_REST  = 3'd3;
  localparam logic [2:0] PH_VALUE      = 3'd4;
  localparam logic [2:0] PH_STRING     = 3'd5;
  localparam logic [2:0] PH_NUMBER     = 3'd6;
  localparam logic [2:0] PH_SEP        = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [1:0]  esc, esc_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [63:0] acc, acc_next;
  logic [CW-1:0] cnt, cnt_next;
  logic        comma, comma_next;
  logic [2:0]  held, held_next;

  logic [2:0]  st, st_out, kind;
  logic [7:0]  obyte, str_val;
  logic [CW-1:0] olen;
  logic [63:0] onum;
  logic        str_req;
  logic [63:0] acc_x10;
  logic [CW+sip_pkg::LEN_W-1:0] olen_ext;

  logic [2:0]  r_status, r_kind;
  logic [7:0]  r_byte;
  logic [sip_pkg::LEN_W-1:0] r_len;
  logic [63:0] r_num;

  assign pop      = q_valid && (!m_tvalid || m_tready);
  assign acc_x10  = (acc << 3) + (acc << 1);
  assign olen_ext = {{sip_pkg::LEN_W{1'b0}}, olen};

  always_comb begin
    phase_next       = phase;
    esc_next         = esc;
    high_nibble_next = high_nibble;
    acc_next         = acc;
    cnt_next         = cnt;
    comma_next       = comma;
    held_next        = held;
    st               = held;
    kind             = sip_pkg::K_NONE;
    obyte            = '0;
    olen             = '0;
    onum             = '0;
    str_req          = 1'b0;
    str_val          = e.text;

    if (held == sip_pkg::ST_RUN) begin
      case (phase)
        PH_OPEN: begin
          if (e.text == sip_pkg::CH_LBRACE) begin
            comma_next = 1'b0;
            phase_next = PH_ELEM;
          end else begin
            st = sip_pkg::ST_SYNTAX;
          end
        end
        PH_ELEM: begin
          if (e.text == sip_pkg::CH_DOT) begin
            phase_next = PH_NAME_FIRST;
          end else if (e.text == sip_pkg::CH_RBRACE && comma) begin
            st = sip_pkg::ST_OK;
          end else begin
            st = sip_pkg::ST_SYNTAX;
          end
        end
        PH_NAME_FIRST: begin
          if (!e.letter) begin
            st = sip_pkg::ST_SYNTAX;
          end else begin
            cnt_next   = CW'(1);
            kind       = sip_pkg::K_NAME;
            obyte      = e.text;
            phase_next = PH_NAME_REST;
          end
        end
        PH_NAME_REST: begin
          if (e.name_char) begin
            if (cnt >= CW'(MAX_NAME)) begin
              st = sip_pkg::ST_LONG;
            end else begin
              cnt_next = cnt + 1'b1;
              kind     = sip_pkg::K_NAME;
              obyte    = e.text;
            end
          end else if (e.text == sip_pkg::CH_EQUALS) begin
            kind       = sip_pkg::K_NAME_END;
            olen       = cnt;
            cnt_next   = '0;
            phase_next = PH_VALUE;
          end else begin
            st = sip_pkg::ST_SYNTAX;
          end
        end
        PH_VALUE: begin
          if (e.text == sip_pkg::CH_QUOTE) begin
            cnt_next   = '0;
            esc_next   = 2'd0;
            phase_next = PH_STRING;
          end else if (e.digit) begin
            acc_next   = {60'd0, e.text[3:0]};
            phase_next = PH_NUMBER;
          end else begin
            st = sip_pkg::ST_SYNTAX;
          end
        end
        PH_STRING: begin
          case (esc)
            2'd0: begin
              if (e.text == sip_pkg::CH_BSLASH) begin
                esc_next = 2'd1;
              end else if (e.text == sip_pkg::CH_QUOTE) begin
                kind       = sip_pkg::K_STR_END;
                olen       = cnt;
                cnt_next   = '0;
                phase_next = PH_SEP;
              end else begin
                str_req = 1'b1;
              end
            end
            2'd1: begin
              esc_next = 2'd0;
              if (e.text == sip_pkg::CH_QUOTE || e.text == sip_pkg::CH_BSLASH) begin
                str_req = 1'b1;
              end else if (e.text == sip_pkg::CH_LOWER_N) begin
                str_req = 1'b1;
                str_val = sip_pkg::CH_LF;
              end else if (e.text == sip_pkg::CH_LOWER_R) begin
                str_req = 1'b1;
                str_val = sip_pkg::CH_CR;
              end else if (e.text == sip_pkg::CH_ZERO) begin
                str_req = 1'b1;
                str_val = sip_pkg::CH_NUL;
              end else if (e.text == sip_pkg::CH_LOWER_X) begin
                esc_next = 2'd2;
              end else begin
                st = sip_pkg::ST_ESC;
              end
            end
            2'd2: begin
              if (!e.hex_ok) begin
                st = sip_pkg::ST_ESC;
              end else begin
                high_nibble_next = e.hex_val;
                esc_next         = 2'd3;
              end
            end
            default: begin
              esc_next = 2'd0;
              if (!e.hex_ok) begin
                st = sip_pkg::ST_ESC;
              end else begin
                str_req          = 1'b1;
                str_val          = {high_nibble, e.hex_val};
                high_nibble_next = '0;
              end
            end
          endcase
        end
        PH_NUMBER: begin
          if (e.digit) begin
            acc_next = acc_x10 + {60'd0, e.text[3:0]};
          end else begin
            kind     = sip_pkg::K_NUM_END;
            onum     = acc;
            acc_next = '0;
            if (e.text == sip_pkg::CH_COMMA) begin
              comma_next = 1'b1;
              phase_next = PH_ELEM;
              st         = sip_pkg::ST_RUN;
            end else if (e.text == sip_pkg::CH_RBRACE) begin
              st = sip_pkg::ST_OK;
            end else begin
              st = sip_pkg::ST_SYNTAX;
            end
          end
        end
        default: begin
          if (e.text == sip_pkg::CH_COMMA) begin
            comma_next = 1'b1;
            phase_next = PH_ELEM;
            st         = sip_pkg::ST_RUN;
          end else if (e.text == sip_pkg::CH_RBRACE) begin
            st = sip_pkg::ST_OK;
          end else begin
            st = sip_pkg::ST_SYNTAX;
          end
        end
      endcase

      if (str_req) begin
        if (cnt >= CW'(MAX_STRING)) begin
          st = sip_pkg::ST_LONG;
        end else begin
          cnt_next = cnt + 1'b1;
          kind     = sip_pkg::K_STR;
          obyte    = str_val;
        end
      end
      held_next = st;
    end

    st_out = st;
    if (e.fin) begin
      if (st == sip_pkg::ST_RUN) begin
        st_out = sip_pkg::ST_EARLY;
      end
      phase_next       = PH_OPEN;
      esc_next         = '0;
      high_nibble_next = '0;
      acc_next         = '0;
      cnt_next         = '0;
      comma_next       = 1'b0;
      held_next        = sip_pkg::ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OPEN;
      esc         <= '0;
      high_nibble <= '0;
      acc         <= '0;
      cnt         <= '0;
      comma       <= 1'b0;
      held        <= sip_pkg::ST_RUN;
      m_tvalid    <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        esc         <= esc_next;
        high_nibble <= high_nibble_next;
        acc         <= acc_next;
        cnt         <= cnt_next;
        comma       <= comma_next;
        held        <= held_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_status <= st_out;
      r_kind   <= kind;
      r_byte   <= obyte;
      r_len    <= olen_ext[sip_pkg::LEN_W-1:0];
      r_num    <= onum;
    end
  end

  assign m_tdata = {2'b00, r_num, r_len, r_byte, r_status};
  assign m_tuser = r_kind;

endmodule

// ===== hw/rtl/struct_initializer_parser.sv =====
// channel   | valid/ready        | payload
// ----------+--------------------+----------------------------------------------
// in        | s_tvalid/s_tready  | s_tdata text_byte, s_tlast final_byte
// out       | m_tvalid/m_tready  | m_tdata status/out_byte/value_length/number,
//           |                    | m_tuser out_kind
// One byte per cycle sustained unless the output stalls; an accepted request is
// written into the queue, then goes through the parser register to the output.
// The back part handles one byte per cycle unless the output stalls.
// Reset empties the four-entry queue and returns the parser to expect '{'.
// A stalled output holds the back part; the queue keeps taking input until full.
module struct_initializer_parser #(
  parameter int MAX_STRING = sip_pkg::MAX_STRING_DEF,
  parameter int MAX_NAME   = sip_pkg::MAX_NAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sip_pkg::IN_DATA_W-1:0]  s_tdata,  // text_byte[7:0]
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sip_pkg::OUT_DATA_W-1:0] m_tdata,  // status[2:0], out_byte[10:3],
                                                   // value_length[21:11],
                                                   // number_value[85:22], zero[87:86]
  output logic [sip_pkg::OUT_USER_W-1:0] m_tuser   // out_kind[2:0]
);

  logic            q_full;
  logic            push;
  logic            pop;
  logic            q_valid;
  sip_pkg::class_t wr_entry;
  sip_pkg::class_t rd_entry;

  sip_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  sip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rd_entry  (rd_entry)
  );

  sip_back #(
    .MAX_STRING (MAX_STRING),
    .MAX_NAME   (MAX_NAME)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .e        (rd_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_byte_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sip_pkg::K_NAME || m_tuser == sip_pkg::K_STR)
    |-> (m_tdata[2:0] == sip_pkg::ST_RUN || m_tdata[2:0] == sip_pkg::ST_EARLY))
    else $error("name or string byte reported with a verdict");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sip_pkg::K_NONE |-> m_tdata[85:3] == '0)
    else $error("empty result carries payload");

  a_num_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sip_pkg::K_NUM_END |-> m_tdata[85:22] == '0)
    else $error("number value outside number end");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("queue written while full");

endmodule

// ===== bench/tb_struct_initializer_parser.sv =====
module tb_struct_initializer_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import sip_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [2:0] {
    P_OPEN, P_ELEM, P_NAME_FIRST, P_NAME_REST, P_VALUE, P_STRING, P_NUMBER, P_SEP
  } scan_phase_e;

  typedef enum logic [1:0] {ESC_IDLE, ESC_LEAD, ESC_HIGH, ESC_LOW} escape_e;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
  } text_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  kind;
    logic [7:0]  obyte;
    logic [10:0] len;
    logic [63:0] num;
  } parse_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  text_req_t  pending_bytes[$];
  parse_out_t expected_out[$];
  logic [7:0] frame_q[$];

  scan_phase_e scan_phase;
  escape_e     escape_state;
  logic [3:0]  high_nibble;
  logic [63:0] number_acc;
  int          char_count;
  logic        comma_seen;
  logic [2:0]  held_status;

  int sent_count = 0;
  int recv_count = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  struct_initializer_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void parser_clear();
    scan_phase   = P_OPEN;
    escape_state = ESC_IDLE;
    high_nibble  = '0;
    number_acc   = '0;
    char_count   = 0;
    comma_seen   = 1'b0;
    held_status  = ST_RUN;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    if (is_digit(b)) return {1'b1, 4'(b - CH_ZERO)};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 10)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 10)};
    return '0;
  endfunction

  function automatic void string_push(logic [7:0] v, inout parse_out_t r);
    if (char_count >= MAX_STRING_DEF) begin
      r.status = ST_LONG;
    end else begin
      char_count++;
      r.kind  = K_STR;
      r.obyte = v;
    end
  endfunction

  function automatic void separator_step(logic [7:0] b, inout parse_out_t r);
    if (b == CH_COMMA) begin
      comma_seen = 1'b1;
      scan_phase = P_ELEM;
    end else if (b == CH_RBRACE) begin
      r.status = ST_OK;
    end else begin
      r.status = ST_SYNTAX;
    end
  endfunction

  function automatic parse_out_t parse_step(logic [7:0] b, logic fin);
    parse_out_t r;
    logic [4:0] hx;
    r = '0;
    r.status = held_status;
    if (held_status == ST_RUN) begin
      case (scan_phase)
        P_OPEN: begin
          if (b == CH_LBRACE) begin
            comma_seen = 1'b0;
            scan_phase = P_ELEM;
          end else r.status = ST_SYNTAX;
        end
        P_ELEM: begin
          if (b == CH_DOT) scan_phase = P_NAME_FIRST;
          else if (b == CH_RBRACE && comma_seen) r.status = ST_OK;
          else r.status = ST_SYNTAX;
        end
        P_NAME_FIRST: begin
          if (!is_letter(b)) begin
            r.status = ST_SYNTAX;
          end else begin
            char_count = 1;
            r.kind = K_NAME;
            r.obyte = b;
            scan_phase = P_NAME_REST;
          end
        end
        P_NAME_REST: begin
          if (is_letter(b) || is_digit(b) || b == CH_DOLLAR || b == CH_UNDER) begin
            if (char_count >= MAX_NAME_DEF) begin
              r.status = ST_LONG;
            end else begin
              char_count++;
              r.kind = K_NAME;
              r.obyte = b;
            end
          end else if (b == CH_EQUALS) begin
            r.kind = K_NAME_END;
            r.len = char_count[10:0];
            char_count = 0;
            scan_phase = P_VALUE;
          end else r.status = ST_SYNTAX;
        end
        P_VALUE: begin
          if (b == CH_QUOTE) begin
            char_count = 0;
            escape_state = ESC_IDLE;
            scan_phase = P_STRING;
          end else if (is_digit(b)) begin
            number_acc = 64'(b - CH_ZERO);
            scan_phase = P_NUMBER;
          end else r.status = ST_SYNTAX;
        end
        P_STRING: begin
          case (escape_state)
            ESC_IDLE: begin
              if (b == CH_BSLASH) begin
                escape_state = ESC_LEAD;
              end else if (b == CH_QUOTE) begin
                r.kind = K_STR_END;
                r.len = char_count[10:0];
                char_count = 0;
                scan_phase = P_SEP;
              end else string_push(b, r);
            end
            ESC_LEAD: begin
              escape_state = ESC_IDLE;
              if (b == CH_QUOTE || b == CH_BSLASH) string_push(b, r);
              else if (b == CH_LOWER_N) string_push(CH_LF, r);
              else if (b == CH_LOWER_R) string_push(CH_CR, r);
              else if (b == CH_ZERO) string_push(CH_NUL, r);
              else if (b == CH_LOWER_X) escape_state = ESC_HIGH;
              else r.status = ST_ESC;
            end
            ESC_HIGH: begin
              hx = hex_digit(b);
              if (!hx[4]) begin
                r.status = ST_ESC;
              end else begin
                high_nibble = hx[3:0];
                escape_state = ESC_LOW;
              end
            end
            default: begin
              hx = hex_digit(b);
              escape_state = ESC_IDLE;
              if (!hx[4]) begin
                r.status = ST_ESC;
              end else begin
                string_push({high_nibble, hx[3:0]}, r);
                high_nibble = '0;
              end
            end
          endcase
        end
        P_NUMBER: begin
          if (is_digit(b)) begin
            number_acc = number_acc * 64'd10 + 64'(b - CH_ZERO);
          end else begin
            r.kind = K_NUM_END;
            r.num = number_acc;
            number_acc = '0;
            separator_step(b, r);
          end
        end
        default: separator_step(b, r);
      endcase
      held_status = r.status;
    end
    if (fin) begin
      if (r.status == ST_RUN) r.status = ST_EARLY;
      parser_clear();
    end
    return r;
  endfunction

  function automatic int pick_gap(logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    int c;
    c = $urandom_range(0, 51);
    return (c < 26) ? 8'("a" + c) : 8'("A" + c - 26);
  endfunction

  function automatic void add_name(int n);
    int r;
    frame_q.push_back(pick_letter());
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(0, 63);
      if (r < 52) frame_q.push_back(pick_letter());
      else if (r < 62) frame_q.push_back(8'(CH_ZERO + r - 52));
      else if (r == 62) frame_q.push_back(CH_DOLLAR);
      else frame_q.push_back(CH_UNDER);
    end
  endfunction

  function automatic void add_number(int digits);
    for (int i = 0; i < digits; i++) frame_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic void add_string(int n, logic broken);
    int r;
    logic [7:0] v;
    logic [4:0] hx;
    frame_q.push_back(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      v = 8'($urandom_range(0, 255));
      if (r < 50) begin
        if (v == CH_QUOTE || v == CH_BSLASH) frame_q.push_back(CH_BSLASH);
        frame_q.push_back(v);
      end else if (r < 65) begin
        frame_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: frame_q.push_back(CH_LOWER_N);
          1: frame_q.push_back(CH_LOWER_R);
          default: frame_q.push_back(CH_ZERO);
        endcase
      end else if (r < 80) begin
        frame_q.push_back(CH_BSLASH);
        frame_q.push_back(CH_LOWER_X);
        frame_q.push_back(hex_char(v[7:4]));
        frame_q.push_back(hex_char(v[3:0]));
      end else begin
        frame_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        if (frame_q[$] == CH_QUOTE || frame_q[$] == CH_BSLASH) begin
          frame_q[$] = CH_BSLASH;
          frame_q.push_back(CH_BSLASH);
        end
      end
    end
    if (broken) begin
      frame_q.push_back(CH_BSLASH);
      r = $urandom_range(0, 2);
      if (r == 0) begin
        do v = 8'($urandom_range(0, 255));
        while (v == CH_QUOTE || v == CH_BSLASH || v == CH_LOWER_N || v == CH_LOWER_R ||
               v == CH_ZERO || v == CH_LOWER_X);
        frame_q.push_back(v);
      end else begin
        frame_q.push_back(CH_LOWER_X);
        if (r == 2) frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
        do begin
          v = 8'($urandom_range(0, 255));
          hx = hex_digit(v);
        end while (hx[4]);
        frame_q.push_back(v);
      end
    end
    frame_q.push_back(CH_QUOTE);
  endfunction

  function automatic void add_initializer(logic broken);
    int n;
    int spoilt;
    n = $urandom_range(1, 4);
    spoilt = broken ? $urandom_range(0, n - 1) : -1;
    frame_q.push_back(CH_LBRACE);
    for (int i = 0; i < n; i++) begin
      if (i > 0) frame_q.push_back(CH_COMMA);
      frame_q.push_back(CH_DOT);
      add_name($urandom_range(1, 12));
      frame_q.push_back(CH_EQUALS);
      if (i != spoilt && $urandom_range(0, 1)) add_number($urandom_range(1, 24));
      else add_string($urandom_range(0, 16), i == spoilt);
    end
    if ($urandom_range(0, 9) < 3) frame_q.push_back(CH_COMMA);
    frame_q.push_back(CH_RBRACE);
  endfunction

  function automatic int send_frame();
    int n;
    n = frame_q.size();
    foreach (frame_q[i]) pending_bytes.push_back('{text: frame_q[i], fin: (i == n - 1)});
    frame_q.delete();
    return n;
  endfunction

  initial begin
    int random_items;
    int r;
    int keep;
    parser_clear();
    random_items = 0;

    add_text("{}");
    void'(send_frame());
    add_text("{.a=5x");
    frame_q.push_back(8'hFF);
    void'(send_frame());
    add_text("{.b=7,}");
    void'(send_frame());
    add_text("{.c");
    frame_q.push_back(CH_NUL);
    void'(send_frame());
    add_text("{.e=1}");
    void'(send_frame());
    add_text("{");
    void'(send_frame());

    for (int k = 0; k < 4; k++) begin
      add_text("{.");
      if (k < 2) begin
        add_name(MAX_NAME_DEF + k);
        add_text("=1}");
      end else begin
        add_text("s=");
        add_string(MAX_STRING_DEF + k - 2, 1'b0);
        add_text("}");
      end
      void'(send_frame());
    end

    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 92) begin
        add_initializer(r >= 65 && r < 75);
        if (r < 65 && $urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
        end else if (r >= 75 && r < 83) begin
          keep = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > keep) void'(frame_q.pop_back());
        end else if (r >= 83) begin
          frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end else begin
        if ($urandom_range(0, 1)) frame_q.push_back(CH_LBRACE);
        repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      random_items += send_frame();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_out.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_struct_initializer_parser: done, clean");
    end else begin
      $display("tb_struct_initializer_parser: done, errors");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_text
    text_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_out.push_back(parse_step(s_tdata, s_tlast));
        sent_count++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until taken
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        req = pending_bytes.pop_front();
        s_tdata  <= req.text;
        s_tlast  <= req.fin;
        s_tvalid <= 1'b1;
        src_gap = pick_gap(((sent_count / 160) % 4) == 3);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    parse_out_t want;
    parse_out_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.kind   = m_tuser;
        got.obyte  = m_tdata[10:3];
        got.len    = m_tdata[21:11];
        got.num    = m_tdata[85:22];
        recv_count++;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d with nothing pending: status %0d kind %0d byte %h len %0d num %0d",
                     recv_count, got.status, got.kind, got.obyte, got.len, got.num);
        end else begin
          want = expected_out.pop_front();
          if (got.status !== want.status || got.kind !== want.kind ||
              got.obyte !== want.obyte || got.len !== want.len || got.num !== want.num) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result %0d: status %0d/%0d kind %0d/%0d byte %h/%h len %0d/%0d",
                        " num %0d/%0d (expected/actual)"},
                       recv_count, want.status, got.status, want.kind, got.kind,
                       want.obyte, got.obyte, want.len, got.len, want.num, got.num);
          end
        end
        sink_gap = pick_gap(((recv_count / 160) % 4) == 1);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_struct_initializer_parser: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
